[hdl/parallel_flash_command_decoder_macros.svh]
// ----------------------------------------------------------------------------
// parallel_flash_command_decoder_macros
// Assertion macros used by the checker file of the flash command decoder.
// ----------------------------------------------------------------------------
`ifndef PARALLEL_FLASH_COMMAND_DECODER_MACROS_SVH
`define PARALLEL_FLASH_COMMAND_DECODER_MACROS_SVH

// Check a property on every clock edge outside reset.
`define PFCD_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("pfcd assertion failed");

// Check a property on every clock edge, reset included.
`define PFCD_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("pfcd assertion failed");

`endif

[hdl/pfcd_pkg.sv]
// ----------------------------------------------------------------------------
// pfcd_pkg
// Sizes, operation codes and the operation record of the flash command decoder.
// ----------------------------------------------------------------------------
package pfcd_pkg;

    // Geometry; bank and sector sizes are powers of two.
    localparam int BANK_BYTES   = 65536;
    localparam int SECTOR_BYTES = 4096;
    localparam int NUM_BANKS    = 2;
    localparam int ARRAY_BYTES  = BANK_BYTES * NUM_BANKS;

    localparam int ADDR_W   = 16;
    localparam int DATA_W   = 8;
    localparam int ID_W     = 16;
    localparam int BANK_AW  = $clog2(BANK_BYTES);
    localparam int ARRAY_AW = $clog2(ARRAY_BYTES);

    // A sector erase never reaches past the end of its bank.
    localparam int ERASE_SPAN = (SECTOR_BYTES < BANK_BYTES) ? SECTOR_BYTES : BANK_BYTES;
    localparam logic [ARRAY_AW-1:0] ERASE_MASK = ARRAY_AW'(ERASE_SPAN - 1);
    localparam logic [ARRAY_AW-1:0] ARRAY_LAST = ARRAY_AW'(ARRAY_BYTES - 1);

    // Configuration port
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;
    localparam logic [CFG_IDX_W-1:0] CFG_EXTENDED_MODE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_DEVICE_ID     = 1'b1;

    // Queue depths (powers of two)
    localparam int OP_DEPTH      = 2;
    localparam int OUT_DEPTH     = 4;
    localparam int MAX_IN_FLIGHT = OP_DEPTH + OUT_DEPTH;

    typedef enum logic [2:0] {
        OP_READ,          // read the array at addr
        OP_RESULT,        // result byte carried in data
        OP_PROGRAM,       // array[addr] &= data
        OP_ERASE_SECTOR,  // erase the sector holding addr
        OP_ERASE_CHIP     // erase the whole array
    } t_op_kind;

    typedef struct packed {
        t_op_kind              kind;
        logic [ARRAY_AW-1:0]   addr;
        logic [DATA_W-1:0]     data;
    } t_op;

endpackage

[hdl/pfcd_op_fifo.sv]
// ----------------------------------------------------------------------------
// pfcd_op_fifo
// Short queue of classified operations between the command front end and
// the array engine.
// ----------------------------------------------------------------------------
module pfcd_op_fifo import pfcd_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_op  i_op,
    output logic o_full,
    input  logic i_pop,
    output t_op  o_op,
    output logic o_empty
);

    localparam int PTR_W = (OP_DEPTH > 1) ? $clog2(OP_DEPTH) : 1;
    localparam int CNT_W = $clog2(OP_DEPTH + 1);

    t_op              r_buf [OP_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;

    assign o_full  = (r_count == CNT_W'(OP_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_op    = r_buf[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            unique case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_buf[r_wr_ptr] <= i_op;
        end
    end

endmodule

[hdl/pfcd_front.sv]
// ----------------------------------------------------------------------------
// pfcd_front
// Bus access front end: holds the configuration and command state, tracks
// the unlock sequence and turns each access into one array operation.
// ----------------------------------------------------------------------------
module pfcd_front import pfcd_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // configuration
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    // bus accesses
    input  logic                  i_push,
    input  logic                  i_action,
    input  logic [ADDR_W-1:0]     i_address,
    input  logic [DATA_W-1:0]     i_write_data,
    output logic                  o_full,
    // downstream
    input  logic                  i_op_full,
    input  logic                  i_clearing,
    output logic                  o_op_push,
    output t_op                   o_op
);

    localparam logic [1:0] PH_IDLE   = 2'd0;
    localparam logic [1:0] PH_FIRST  = 2'd1;
    localparam logic [1:0] PH_SECOND = 2'd2;

    localparam logic [ADDR_W-1:0] UNLOCK1_ADDR  = 16'h5555;
    localparam logic [ADDR_W-1:0] UNLOCK2_ADDR  = 16'h2AAA;
    localparam logic [ADDR_W-1:0] ID_LOW_ADDR   = 16'h0000;
    localparam logic [ADDR_W-1:0] ID_HIGH_ADDR  = 16'h0001;
    localparam logic [ADDR_W-1:0] BANK_SEL_ADDR = 16'h0000;

    localparam logic [DATA_W-1:0] UNLOCK1_DATA     = 8'hAA;
    localparam logic [DATA_W-1:0] UNLOCK2_DATA     = 8'h55;
    localparam logic [DATA_W-1:0] CMD_ID_ENTER     = 8'h90;
    localparam logic [DATA_W-1:0] CMD_ID_EXIT      = 8'hF0;
    localparam logic [DATA_W-1:0] CMD_PROGRAM      = 8'hA0;
    localparam logic [DATA_W-1:0] CMD_BANK_SELECT  = 8'hB0;
    localparam logic [DATA_W-1:0] CMD_ERASE_SETUP  = 8'h80;
    localparam logic [DATA_W-1:0] CMD_ERASE_CHIP   = 8'h10;
    localparam logic [DATA_W-1:0] CMD_ERASE_SECTOR = 8'h30;

    logic              r_extended_mode;
    logic [ID_W-1:0]   r_device_id;
    logic [1:0]        r_phase;
    logic              r_id_mode;
    logic              r_program_armed;
    logic              r_erase_armed;
    logic              r_bank_armed;
    logic              r_current_bank;

    logic [1:0]        n_phase;
    logic              n_id_mode;
    logic              n_program_armed;
    logic              n_erase_armed;
    logic              n_bank_armed;
    logic              n_current_bank;

    logic                accept;
    logic                active_bank;
    logic [ARRAY_AW-1:0] mapped_addr;
    logic                bank_done;
    t_op_kind            op_kind;
    logic [DATA_W-1:0]   op_data;

    assign o_full = i_op_full | i_clearing;
    assign accept = i_push & ~o_full;

    // Bank 1 only exists with two banks and extended mode on.
    assign active_bank = r_extended_mode & r_current_bank & (NUM_BANKS > 1);
    assign mapped_addr = (ARRAY_AW'(active_bank) << BANK_AW)
                       | ARRAY_AW'(i_address[BANK_AW-1:0]);

    always_comb begin
        n_phase         = r_phase;
        n_id_mode       = r_id_mode;
        n_program_armed = r_program_armed;
        n_erase_armed   = r_erase_armed;
        n_bank_armed    = r_bank_armed;
        n_current_bank  = r_current_bank;
        op_kind         = OP_RESULT;
        op_data         = '0;
        bank_done       = 1'b0;

        if (!i_action) begin
            // reads drop the unlock progress but keep armed commands
            n_phase = PH_IDLE;
            if (r_id_mode && i_address == ID_LOW_ADDR) begin
                op_data = r_device_id[DATA_W-1:0];
            end else if (r_id_mode && i_address == ID_HIGH_ADDR) begin
                op_data = r_device_id[ID_W-1:DATA_W];
            end else begin
                op_kind = OP_READ;
            end
        end else if (r_program_armed) begin
            op_kind         = OP_PROGRAM;
            op_data         = i_write_data;
            n_program_armed = 1'b0;
            n_phase         = PH_IDLE;
        end else begin
            if (r_bank_armed) begin
                n_bank_armed = 1'b0;
                if (i_address == BANK_SEL_ADDR) begin
                    if (r_extended_mode) begin
                        n_current_bank = i_write_data[0];
                    end
                    n_phase   = PH_IDLE;
                    bank_done = 1'b1;
                end
            end
            if (!bank_done) begin
                priority if (i_address == UNLOCK1_ADDR && i_write_data == UNLOCK1_DATA
                             && r_phase != PH_SECOND) begin
                    n_phase = PH_FIRST;
                end else if (r_phase == PH_FIRST && i_address == UNLOCK2_ADDR
                             && i_write_data == UNLOCK2_DATA) begin
                    n_phase = PH_SECOND;
                end else if (r_phase == PH_SECOND) begin
                    // command step: any completed command drops the erase setup
                    n_phase       = PH_IDLE;
                    n_erase_armed = 1'b0;
                    if (r_erase_armed && i_write_data == CMD_ERASE_SECTOR) begin
                        op_kind = OP_ERASE_SECTOR;
                    end else if (i_address == UNLOCK1_ADDR) begin
                        if (r_erase_armed && i_write_data == CMD_ERASE_CHIP) begin
                            op_kind = OP_ERASE_CHIP;
                        end else begin
                            unique case (i_write_data)
                                CMD_ID_ENTER:    n_id_mode       = 1'b1;
                                CMD_ID_EXIT:     n_id_mode       = 1'b0;
                                CMD_PROGRAM:     n_program_armed = 1'b1;
                                CMD_BANK_SELECT: n_bank_armed    = 1'b1;
                                CMD_ERASE_SETUP: n_erase_armed   = 1'b1;
                                default:         ;
                            endcase
                        end
                    end
                end else begin
                    n_phase = PH_IDLE;
                end
            end
        end
    end

    assign o_op_push = accept;
    assign o_op.kind = op_kind;
    assign o_op.addr = mapped_addr;
    assign o_op.data = op_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_extended_mode <= 1'b1;
            r_device_id     <= '0;
            r_phase         <= PH_IDLE;
            r_id_mode       <= 1'b0;
            r_program_armed <= 1'b0;
            r_erase_armed   <= 1'b0;
            r_bank_armed    <= 1'b0;
            r_current_bank  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_EXTENDED_MODE: r_extended_mode <= i_cfg_data[0];
                    CFG_DEVICE_ID:     r_device_id     <= i_cfg_data[ID_W-1:0];
                endcase
            end
            if (accept) begin
                r_phase         <= n_phase;
                r_id_mode       <= n_id_mode;
                r_program_armed <= n_program_armed;
                r_erase_armed   <= n_erase_armed;
                r_bank_armed    <= n_bank_armed;
                r_current_bank  <= n_current_bank;
            end
        end
    end

endmodule

[hdl/pfcd_back.sv]
// ----------------------------------------------------------------------------
// pfcd_back
// Array engine: owns the flash array memory, runs reads, read-modify-write
// programs and erase sweeps, and queues one result byte per operation.
// ----------------------------------------------------------------------------
module pfcd_back import pfcd_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_op               i_op,
    input  logic              i_op_empty,
    output logic              o_op_pop,
    output logic              o_clearing,
    output logic              o_empty,
    input  logic              i_pop,
    output logic [DATA_W-1:0] o_read_data
);

    localparam int OUT_PW = (OUT_DEPTH > 1) ? $clog2(OUT_DEPTH) : 1;
    localparam int OUT_CW = $clog2(OUT_DEPTH + 1);
    localparam logic [DATA_W-1:0] ERASED = '1;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_RUN,
        ST_PROG_WR,
        ST_SWEEP
    } t_state;

    t_state              r_state;
    logic [ARRAY_AW-1:0] r_sweep_addr;
    logic [ARRAY_AW-1:0] r_sweep_last;
    logic [ARRAY_AW-1:0] r_prog_addr;
    logic [DATA_W-1:0]   r_prog_data;
    logic                r_res_pend;
    logic                r_res_mem;
    logic [DATA_W-1:0]   r_res_byte;

    logic [DATA_W-1:0]   r_mem [ARRAY_BYTES];
    logic [DATA_W-1:0]   r_mem_q;

    logic [DATA_W-1:0]   r_out_buf [OUT_DEPTH];
    logic [OUT_PW-1:0]   r_out_wr;
    logic [OUT_PW-1:0]   r_out_rd;
    logic [OUT_CW-1:0]   r_out_count;

    logic                room;
    logic                mem_we;
    logic [ARRAY_AW-1:0] mem_waddr;
    logic [DATA_W-1:0]   mem_wdata;
    logic                out_pop;
    logic [DATA_W-1:0]   res_value;

    // Reserve an output slot for the result still in flight.
    assign room = ((OUT_CW + 1)'(r_out_count) + (OUT_CW + 1)'(r_res_pend))
                  < (OUT_CW + 1)'(OUT_DEPTH);
    assign o_op_pop   = (r_state == ST_RUN) && !i_op_empty && room;
    assign o_clearing = (r_state == ST_CLEAR);

    always_comb begin
        unique case (r_state)
            ST_CLEAR, ST_SWEEP: begin
                mem_we    = 1'b1;
                mem_waddr = r_sweep_addr;
                mem_wdata = ERASED;
            end
            ST_PROG_WR: begin
                // programming can only clear bits
                mem_we    = 1'b1;
                mem_waddr = r_prog_addr;
                mem_wdata = r_mem_q & r_prog_data;
            end
            ST_RUN: begin
                mem_we    = 1'b0;
                mem_waddr = r_prog_addr;
                mem_wdata = r_prog_data;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        r_mem_q <= r_mem[i_op.addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_CLEAR;
            r_sweep_addr <= '0;
            r_sweep_last <= ARRAY_LAST;
            r_res_pend   <= 1'b0;
        end else begin
            r_res_pend <= o_op_pop;
            if (o_op_pop) begin
                r_res_mem  <= (i_op.kind == OP_READ);
                r_res_byte <= (i_op.kind == OP_RESULT) ? i_op.data : '0;
            end
            unique case (r_state)
                ST_CLEAR, ST_SWEEP: begin
                    if (r_sweep_addr == r_sweep_last) begin
                        r_state <= ST_RUN;
                    end else begin
                        r_sweep_addr <= r_sweep_addr + 1'b1;
                    end
                end
                ST_PROG_WR: begin
                    r_state <= ST_RUN;
                end
                ST_RUN: begin
                    if (o_op_pop) begin
                        unique case (i_op.kind)
                            OP_READ, OP_RESULT: ;
                            OP_PROGRAM: begin
                                r_prog_addr <= i_op.addr;
                                r_prog_data <= i_op.data;
                                r_state     <= ST_PROG_WR;
                            end
                            OP_ERASE_SECTOR: begin
                                r_sweep_addr <= i_op.addr & ~ERASE_MASK;
                                r_sweep_last <= i_op.addr | ERASE_MASK;
                                r_state      <= ST_SWEEP;
                            end
                            OP_ERASE_CHIP: begin
                                r_sweep_addr <= '0;
                                r_sweep_last <= ARRAY_LAST;
                                r_state      <= ST_SWEEP;
                            end
                        endcase
                    end
                end
            endcase
        end
    end

    // Result queue
    assign out_pop     = i_pop && !o_empty;
    assign o_empty     = (r_out_count == '0);
    assign o_read_data = r_out_buf[r_out_rd];
    assign res_value   = r_res_mem ? r_mem_q : r_res_byte;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_wr    <= '0;
            r_out_rd    <= '0;
            r_out_count <= '0;
        end else begin
            if (r_res_pend) begin
                r_out_wr <= r_out_wr + 1'b1;
            end
            if (out_pop) begin
                r_out_rd <= r_out_rd + 1'b1;
            end
            unique case ({r_res_pend, out_pop})
                2'b10:   r_out_count <= r_out_count + 1'b1;
                2'b01:   r_out_count <= r_out_count - 1'b1;
                default: r_out_count <= r_out_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_res_pend) begin
            r_out_buf[r_out_wr] <= res_value;
        end
    end

endmodule

[hdl/parallel_flash_command_decoder.sv]
// ----------------------------------------------------------------------------
// parallel_flash_command_decoder
// Byte-wide parallel flash with unlock-sequence command set, two banks.
// ----------------------------------------------------------------------------
// Usage:
//   Bus accesses enter through push/full; one result byte per access leaves
//   through empty/pop in order (stored byte, ID byte, or 0 for writes).
//   Configuration writes (extended mode, device ID) take effect at the edge
//   where i_cfg_we is high; the user issues them only while the block is
//   idle; the block itself does not enforce this.
// Timing:
//   An access passes the operation queue, a result register and the result
//   queue before its result shows on o_read_data. Reads and plain writes
//   sustain one access per cycle while pop keeps up and the engine is free.
//   A program reads, then writes back through the single array write port.
//   Sector (4096-byte) and chip erases hold the engine, one byte per cycle.
// Reset:
//   After reset the engine clears the 131072-byte array to 0xFF, one byte a
//   cycle; full stays high until the clear is done.
// Stall:
//   With pop low, up to four results wait and two accesses queue behind
//   them, then full rises; nothing is dropped.
// ----------------------------------------------------------------------------
module parallel_flash_command_decoder import pfcd_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  push,
    output logic                  full,
    input  logic                  i_action,
    input  logic [ADDR_W-1:0]     i_address,
    input  logic [DATA_W-1:0]     i_write_data,
    output logic                  empty,
    input  logic                  pop,
    output logic [DATA_W-1:0]     o_read_data
);

    t_op  front_op;
    logic front_push;
    t_op  back_op;
    logic op_full;
    logic op_empty;
    logic op_pop;
    logic clearing;

    pfcd_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_push       (push),
        .i_action     (i_action),
        .i_address    (i_address),
        .i_write_data (i_write_data),
        .o_full       (full),
        .i_op_full    (op_full),
        .i_clearing   (clearing),
        .o_op_push    (front_push),
        .o_op         (front_op)
    );

    pfcd_op_fifo u_op_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (front_push),
        .i_op    (front_op),
        .o_full  (op_full),
        .i_pop   (op_pop),
        .o_op    (back_op),
        .o_empty (op_empty)
    );

    pfcd_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_op        (back_op),
        .i_op_empty  (op_empty),
        .o_op_pop    (op_pop),
        .o_clearing  (clearing),
        .o_empty     (empty),
        .i_pop       (pop),
        .o_read_data (o_read_data)
    );

endmodule

[hdl/pfcd_checker.sv]
// ----------------------------------------------------------------------------
// pfcd_checker
// Port-level checks of the flash command decoder, bound to the top level.
// ----------------------------------------------------------------------------
`include "parallel_flash_command_decoder_macros.svh"

module pfcd_checker import pfcd_pkg::*; (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              push,
    input logic              full,
    input logic              pop,
    input logic              empty,
    input logic [DATA_W-1:0] o_read_data
);

    localparam int CNT_W = $clog2(MAX_IN_FLIGHT + 2);

    logic [CNT_W-1:0] r_outstanding;
    logic [CNT_W-1:0] n_outstanding;
    logic             in_fire;
    logic             out_fire;

    assign in_fire  = push && !full;
    assign out_fire = pop && !empty;

    always_comb begin
        n_outstanding = r_outstanding;
        unique case ({in_fire, out_fire})
            2'b10:   n_outstanding = r_outstanding + 1'b1;
            2'b01:   n_outstanding = r_outstanding - 1'b1;
            default: n_outstanding = r_outstanding;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_outstanding <= '0;
        end else begin
            r_outstanding <= n_outstanding;
        end
    end

    // hold off input and show no result after any reset cycle
    `PFCD_ASSERT_ALWAYS(a_reset_state, i_clk, !i_rst_n |=> full && empty)
    // no result without an access behind it
    `PFCD_ASSERT(a_no_invented, i_clk, i_rst_n, r_outstanding == '0 |-> empty)
    // queues bound the work in flight
    `PFCD_ASSERT(a_bounded, i_clk, i_rst_n, r_outstanding <= CNT_W'(MAX_IN_FLIGHT))
    // a waiting result holds until taken
    `PFCD_ASSERT(a_out_hold, i_clk, i_rst_n, !empty && !pop |=> !empty && $stable(o_read_data))

endmodule

bind parallel_flash_command_decoder pfcd_checker u_pfcd_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .push        (push),
    .full        (full),
    .pop         (pop),
    .empty       (empty),
    .o_read_data (o_read_data)
);
